[design/pareto_front_ranking_assert.svh]
// Assertion macros shared by the ranking block.
`ifndef PARETO_FRONT_RANKING_ASSERT_SVH
`define PARETO_FRONT_RANKING_ASSERT_SVH
`ifndef SYNTH
`define PFR_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("same-cycle check failed");
`define PFR_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("next-cycle check failed");
`else
`define PFR_ASSERT_IMP(lbl, clk, rstn, a, c)
`define PFR_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

[design/pfr_pkg.sv]
package pfr_pkg;
    localparam int MAX_POINTS = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int OBJ_W      = 32;
    localparam int FRONT_W    = 5;
    localparam logic [FRONT_W-1:0] FRONT_MAX = '1;

    typedef struct packed {
        logic load;
        logic start_set;
        logic latch;
        logic scan;
        logic decide;
        logic next_i;
        logic round_end;
        logic emit_next;
        logic emit_done;
    } t_cmd;

    typedef struct packed {
        logic last_load;
        logic i_last;
        logic j_last;
        logic i_assigned;
        logic all_done;
        logic e_last;
    } t_status;

    // True when point a dominates point b (both objectives minimized).
    function automatic logic dominates(input logic signed [OBJ_W-1:0] a1,
                                       input logic signed [OBJ_W-1:0] a2,
                                       input logic signed [OBJ_W-1:0] b1,
                                       input logic signed [OBJ_W-1:0] b2);
        dominates = (a1 <= b1) && (a2 <= b2) && !((a1 == b1) && (a2 == b2));
    endfunction
endpackage

[design/pfr_ram.sv]
module pfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/pfr_datapath.sv]
module pfr_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pfr_pkg::t_cmd                   i_cmd,
    input  logic signed [pfr_pkg::OBJ_W-1:0] i_objective_one,
    input  logic signed [pfr_pkg::OBJ_W-1:0] i_objective_two,
    output pfr_pkg::t_status                o_status,
    output logic [4:0]                      o_point_index,
    output logic [pfr_pkg::FRONT_W-1:0]     o_front_number
);
    import pfr_pkg::*;

    logic [CNT_W-1:0]   r_count, r_done;
    logic [IDX_W-1:0]   r_i, r_j, r_pj, r_e;
    logic [FRONT_W-1:0] r_front;
    logic [MAX_POINTS-1:0] r_assigned, r_chosen;
    logic [FRONT_W-1:0] r_front_of [MAX_POINTS];
    logic signed [OBJ_W-1:0] r_ai1, r_ai2;
    logic r_dom, r_pend;

    logic [IDX_W-1:0]     ram_addr;
    logic [2*OBJ_W-1:0]   ram_rdata;
    logic signed [OBJ_W-1:0] rd1, rd2;

    always_comb begin
        priority if (i_cmd.load) begin
            ram_addr = r_count[IDX_W-1:0];
        end else if (i_cmd.scan) begin
            ram_addr = r_j;
        end else begin
            ram_addr = r_i;
        end
    end

    pfr_ram #(.WIDTH(2*OBJ_W), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_addr  (ram_addr),
        .i_wdata ({i_objective_one, i_objective_two}),
        .o_rdata (ram_rdata)
    );

    assign rd1 = ram_rdata[2*OBJ_W-1:OBJ_W];
    assign rd2 = ram_rdata[OBJ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_assigned <= '0;
            r_chosen   <= '0;
            r_pend     <= 1'b0;
            r_e        <= '0;
        end else begin
            r_pend <= i_cmd.scan;
            if (i_cmd.load) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.start_set) begin
                r_assigned <= '0;
                r_chosen   <= '0;
            end
            if (i_cmd.decide && !r_dom) begin
                r_chosen[r_i] <= 1'b1;
            end
            if (i_cmd.round_end) begin
                r_assigned <= r_assigned | r_chosen;
                r_chosen   <= '0;
            end
            if (i_cmd.emit_next) begin
                r_e <= r_e + IDX_W'(1);
            end
            if (i_cmd.emit_done) begin
                r_e     <= '0;
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_set) begin
            r_i     <= '0;
            r_front <= '0;
            r_done  <= '0;
        end
        if (i_cmd.latch) begin
            r_ai1 <= rd1;
            r_ai2 <= rd2;
            r_dom <= 1'b0;
            r_j   <= '0;
        end
        if (i_cmd.scan) begin
            r_j  <= r_j + IDX_W'(1);
            r_pj <= r_j;
        end
        // A point only counts as a dominator while it is still unranked.
        if (r_pend && !r_assigned[r_pj] && dominates(rd1, rd2, r_ai1, r_ai2)) begin
            r_dom <= 1'b1;
        end
        if (i_cmd.decide && !r_dom) begin
            r_front_of[r_i] <= r_front;
            r_done          <= r_done + CNT_W'(1);
        end
        if (i_cmd.next_i) begin
            r_i <= r_i + IDX_W'(1);
        end
        if (i_cmd.round_end) begin
            r_i <= '0;
            if (r_front != FRONT_MAX) begin
                r_front <= r_front + FRONT_W'(1);
            end
        end
    end

    assign o_status.last_load  = (r_count == CNT_W'(MAX_POINTS - 1));
    assign o_status.i_last     = (CNT_W'(r_i) == r_count - CNT_W'(1));
    assign o_status.j_last     = (CNT_W'(r_j) == r_count - CNT_W'(1));
    assign o_status.i_assigned = r_assigned[r_i];
    assign o_status.all_done   = (r_done == r_count);
    assign o_status.e_last     = (CNT_W'(r_e) == r_count - CNT_W'(1));

    assign o_point_index  = 5'(r_e);
    assign o_front_number = r_front_of[r_e];
endmodule

[design/pfr_ctrl.sv]
`include "pareto_front_ranking_assert.svh"
module pfr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_final_point,
    input  logic             i_out_ready,
    input  pfr_pkg::t_status i_status,
    output pfr_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import pfr_pkg::*;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_LATCH  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DECIDE = 3'd5;
    localparam logic [2:0] S_ROUND  = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0] r_state, n_state;
    logic in_beat, out_beat;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_beat    = o_out_valid && i_out_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_beat) begin
                    o_cmd.load = 1'b1;
                    if (i_final_point || i_status.last_load) begin
                        o_cmd.start_set = 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (i_status.i_assigned) begin
                    if (i_status.i_last) begin
                        n_state = S_ROUND;
                    end else begin
                        o_cmd.next_i = 1'b1;
                    end
                end else begin
                    n_state = S_LATCH;
                end
            end
            S_LATCH: begin
                o_cmd.latch = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.j_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_status.i_last) begin
                    n_state = S_ROUND;
                end else begin
                    o_cmd.next_i = 1'b1;
                    n_state = S_ISSUE;
                end
            end
            S_ROUND: begin
                o_cmd.round_end = 1'b1;
                n_state = i_status.all_done ? S_EMIT : S_ISSUE;
            end
            S_EMIT: begin
                if (out_beat) begin
                    if (i_status.e_last) begin
                        o_cmd.emit_done = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `PFR_ASSERT_NXT(a_final_stops_load, i_clk, i_rst_n, in_beat && i_final_point, !o_in_ready)
    `PFR_ASSERT_NXT(a_last_beat_reloads, i_clk, i_rst_n, out_beat && i_status.e_last, o_in_ready)
    `PFR_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `PFR_ASSERT_IMP(a_emit_all_ranked, i_clk, i_rst_n, o_out_valid, i_status.all_done)
endmodule

[design/pareto_front_ranking.sv]
// Pareto front ranking of a set of two-objective points, both minimized.
// Input channel (i_in_valid / o_in_ready): one point per beat, signed
// objectives; i_final_point marks the last point of a set. A set also ends
// when the store of 32 points fills.
// Output channel (o_out_valid / i_out_ready): after ranking, one beat per
// stored point in load order with its index and front number; the last
// beat of a set has o_last_of_set high. No point is taken while a set is
// being ranked or emitted.
// Ranking peels one front per round; each round visits every point and
// streams all n stored points past each unranked one from the objective
// RAM: each unranked point takes an issue, a latch, a scan of all n points,
// a drain and a decide step, a point already ranked takes only the issue
// step, and each round ends with a round step. That RAM has a single read
// port, so the scan reads the stored points one at a time.
// Emitting moves to the next point on each taken beat; a stall holds the
// current beat unchanged until it is taken. Reset (synchronous, active
// low) empties the store and returns the block to loading.
module pareto_front_ranking (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [pfr_pkg::OBJ_W-1:0] i_objective_one,
    input  logic signed [pfr_pkg::OBJ_W-1:0] i_objective_two,
    input  logic                            i_final_point,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [4:0]                      o_point_index,
    output logic [pfr_pkg::FRONT_W-1:0]     o_front_number,
    output logic                            o_last_of_set
);
    import pfr_pkg::*;

    t_cmd    cmd;
    t_status status;

    pfr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_final_point (i_final_point),
        .i_out_ready   (i_out_ready),
        .i_status      (status),
        .o_cmd         (cmd),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid)
    );

    pfr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_objective_one (i_objective_one),
        .i_objective_two (i_objective_two),
        .o_status        (status),
        .o_point_index   (o_point_index),
        .o_front_number  (o_front_number)
    );

    assign o_last_of_set = status.e_last;
endmodule
